FILE: design/sspg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the servo pulse generator.
`default_nettype none

package sspg_pkg;

  // Sine table resolution: quarter wave of 2^SINE_TABLE_BITS + 1 entries in Q1.15
  localparam int SINE_TABLE_BITS = 8;
  localparam int QTR_N           = 1 << SINE_TABLE_BITS;
  localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_FREQ      = 3'd0;
  localparam logic [2:0] CFG_AMPLITUDE = 3'd1;
  localparam logic [2:0] CFG_CENTER    = 3'd2;
  localparam logic [2:0] CFG_PULSE_MIN = 3'd3;
  localparam logic [2:0] CFG_PULSE_CTR = 3'd4;
  localparam logic [2:0] CFG_PULSE_MAX = 3'd5;

  // Reset values of the configuration registers
  localparam logic [14:0] FREQ_RESET      = 15'd1000;
  localparam logic [14:0] AMPLITUDE_RESET = 15'd3000;
  localparam logic [14:0] CENTER_RESET    = 15'd0;
  localparam logic [15:0] PULSE_MIN_RESET = 16'd500;
  localparam logic [15:0] PULSE_CTR_RESET = 16'd1500;
  localparam logic [15:0] PULSE_MAX_RESET = 16'd2500;

  // Arithmetic constants
  localparam logic [29:0] NANO       = 30'd1000000000;  // 1e-9 turn units per turn
  localparam logic [29:0] DEN_Q15    = 30'd589824000;   // 18000 centideg * 2^15
  localparam logic [32:0] OFFSET_Q15 = 33'd294912000;   // 9000 centideg * 2^15

  // Serial multiplier: 31-bit multiplicand, 20-bit multiplier, one bit per cycle
  localparam int MUL_A_W     = 31;
  localparam int MUL_B_W     = 20;
  localparam int MUL_P_W     = 47;
  localparam int MUL_ACC_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS   = MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

  // Restoring divider: up to 67 dividend bits, 30-bit divisor, one quotient bit per cycle
  localparam int DIV_N_W          = 67;
  localparam int DIV_D_W          = 30;
  localparam int DIV_Q_W          = 32;
  localparam int DIV_PHASE_STEPS  = 67;
  localparam int DIV_PULSE_STEPS  = 47;
  localparam int DIV_CNT_W        = $clog2(DIV_PHASE_STEPS + 1);

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   mcand;
    logic [MUL_B_W-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  // Sine table, built at elaboration by a truncated Taylor series in Q30
  typedef logic [15:0] sine_tab_t [QTR_N+1];

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [8] = '{64'sd1, 64'sd6, 64'sd20, 64'sd42,
                                        64'sd72, 64'sd110, 64'sd156, 64'sd210};

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    mag;
    longint    s;
    for (int k = 0; k <= QTR_N; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >>> SINE_TABLE_BITS;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n < 8; n++) begin
        mag  = (term < 0) ? -term : term;
        mag  = ((mag * x2) >>> 30) / TAYLOR_DIV[n];
        term = (term < 0) ? mag : -mag;
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      s      = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      tab[k] = 16'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

FILE: design/sine_servo_pulse_generator.sv
// A running tick passes through three 20-step serial multiplies and the 67-step and
// 47-step serial divisions before its pulse is given; the next request is taken once
// the pulse is in the output register. Ticks whose pulse settles on a limit early (max
// not above min, or angle below -90 deg) skip the span multiply and the pulse division.
// A tick while stopped goes straight to the done state with the centre pulse; start and
// stop give no pulse.
// Reset (rst_n low, synchronous): stopped, phase zero, registers at their defaults.
`default_nettype none

module sine_servo_pulse_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [19:0] in_elapsed_us,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pulse_us,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_INC,    // frequency times elapsed time
    ST_DIV_INC,    // scale to 2^-32 turn, drop whole turns
    ST_SINE,       // table lookup, start amplitude multiply
    ST_MUL_AMP,    // amplitude times sine
    ST_SPAN,       // pick a limit or start the span multiply
    ST_MUL_SPAN,   // angle offset times pulse span
    ST_DIV_PULSE,  // divide by the full angle range
    ST_DONE        // hand the pulse to the output register
  } state_t;

  // Configuration registers
  logic [14:0] freq_r;
  logic [14:0] amplitude_r;
  logic [14:0] center_r;
  logic [15:0] pulse_min_r;
  logic [15:0] pulse_ctr_r;
  logic [15:0] pulse_max_r;

  // Control and datapath state
  state_t             state_r;
  logic               running_r;
  logic [31:0]        phase_r;
  logic               sign_r;
  logic [32:0]        num_r;
  logic [15:0]        result_r;
  logic               out_valid_r;
  logic [15:0]        out_pulse_us_r;
  sspg_pkg::mul_req_t mul_req_r;
  sspg_pkg::div_req_t div_req_r;

  // Arithmetic unit results
  logic                         mul_done;
  logic [sspg_pkg::MUL_P_W-1:0] mul_prod;
  logic                         div_done;
  logic [sspg_pkg::DIV_Q_W-1:0] div_quot;

  // Combinational helpers
  logic                            in_accept;
  logic [sspg_pkg::SINE_TABLE_BITS-1:0] tab_idx;
  logic [sspg_pkg::SINE_IDX_W-1:0] tab_addr;
  logic [15:0]                     sine_mag;
  logic [14:0]                     amp_mag;
  logic [32:0]                     amp_term;
  logic [32:0]                     num_nxt;
  logic [15:0]                     span;
  logic [18:0]                     pulse_sum;
  logic [15:0]                     pulse_clamped;

  sspg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sspg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    // Quarter-wave lookup: odd quadrants read the table mirrored
    tab_idx  = phase_r[29 -: sspg_pkg::SINE_TABLE_BITS];
    tab_addr = phase_r[30]
             ? sspg_pkg::SINE_IDX_W'(sspg_pkg::QTR_N) - {1'b0, tab_idx}
             : {1'b0, tab_idx};
    sine_mag = sspg_pkg::SINE_TAB[tab_addr];
    amp_mag  = amplitude_r[14] ? 15'(-amplitude_r) : amplitude_r;

    // Angle in Q15 centidegrees, offset so that -90 deg sits at zero
    amp_term = sign_r ? 33'(-{2'b0, mul_prod[30:0]}) : {2'b0, mul_prod[30:0]};
    num_nxt  = {{3{center_r[14]}}, center_r, 15'b0} + amp_term + sspg_pkg::OFFSET_Q15;

    span      = pulse_max_r - pulse_min_r;
    pulse_sum = {3'b0, pulse_min_r} + {1'b0, div_quot[17:0]};
    pulse_clamped = (pulse_sum > {3'b0, pulse_max_r}) ? pulse_max_r : pulse_sum[15:0];
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r      <= sspg_pkg::FREQ_RESET;
      amplitude_r <= sspg_pkg::AMPLITUDE_RESET;
      center_r    <= sspg_pkg::CENTER_RESET;
      pulse_min_r <= sspg_pkg::PULSE_MIN_RESET;
      pulse_ctr_r <= sspg_pkg::PULSE_CTR_RESET;
      pulse_max_r <= sspg_pkg::PULSE_MAX_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sspg_pkg::CFG_FREQ:      freq_r      <= cfg_data[14:0];
        sspg_pkg::CFG_AMPLITUDE: amplitude_r <= cfg_data[14:0];
        sspg_pkg::CFG_CENTER:    center_r    <= cfg_data[14:0];
        sspg_pkg::CFG_PULSE_MIN: pulse_min_r <= cfg_data;
        sspg_pkg::CFG_PULSE_CTR: pulse_ctr_r <= cfg_data;
        sspg_pkg::CFG_PULSE_MAX: pulse_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: one request at a time through the shared multiplier and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      running_r       <= 1'b0;
      phase_r         <= '0;
      out_valid_r     <= 1'b0;
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      mul_req_r.start <= 1'b0;
      div_req_r.start <= 1'b0;

      // Drop the held pulse once the consumer takes it
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_kind)
              sspg_pkg::KIND_START: begin
                running_r <= 1'b1;
                phase_r   <= '0;
              end
              sspg_pkg::KIND_STOP: begin
                running_r <= 1'b0;
              end
              sspg_pkg::KIND_TICK: begin
                if (running_r) begin
                  mul_req_r.start  <= 1'b1;
                  mul_req_r.mcand  <= {16'b0, freq_r};
                  mul_req_r.mplier <= in_elapsed_us;
                  state_r          <= ST_MUL_INC;
                end else begin
                  result_r <= pulse_ctr_r;
                  state_r  <= ST_DONE;
                end
              end
              default: ;  // unused kind: ignore the request
            endcase
          end
        end

        ST_MUL_INC: begin
          if (mul_done) begin
            // Phase step = (f*dt mod 1e9) * 2^32 / 1e9, i.e. low word of f*dt*2^32/1e9
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {mul_prod[34:0], 32'b0};
            div_req_r.divisor  <= sspg_pkg::NANO;
            div_req_r.steps    <= sspg_pkg::DIV_CNT_W'(sspg_pkg::DIV_PHASE_STEPS);
            state_r            <= ST_DIV_INC;
          end
        end

        ST_DIV_INC: begin
          if (div_done) begin
            phase_r <= phase_r + div_quot;
            state_r <= ST_SINE;
          end
        end

        ST_SINE: begin
          // Multiply magnitudes; the sign is amplitude sign xor upper half-turn
          mul_req_r.start  <= 1'b1;
          mul_req_r.mcand  <= {16'b0, amp_mag};
          mul_req_r.mplier <= {4'b0, sine_mag};
          sign_r           <= amplitude_r[14] ^ phase_r[31];
          state_r          <= ST_MUL_AMP;
        end

        ST_MUL_AMP: begin
          if (mul_done) begin
            num_r   <= num_nxt;
            state_r <= ST_SPAN;
          end
        end

        ST_SPAN: begin
          if (pulse_max_r <= pulse_min_r) begin
            // Empty or inverted range: the upper clamp always wins
            result_r <= pulse_max_r;
            state_r  <= ST_DONE;
          end else if (num_r[32]) begin
            // Below -90 deg: hold at the minimum pulse
            result_r <= pulse_min_r;
            state_r  <= ST_DONE;
          end else begin
            mul_req_r.start  <= 1'b1;
            mul_req_r.mcand  <= num_r[30:0];
            mul_req_r.mplier <= {4'b0, span};
            state_r          <= ST_MUL_SPAN;
          end
        end

        ST_MUL_SPAN: begin
          if (mul_done) begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {mul_prod, 20'b0};
            div_req_r.divisor  <= sspg_pkg::DEN_Q15;
            div_req_r.steps    <= sspg_pkg::DIV_CNT_W'(sspg_pkg::DIV_PULSE_STEPS);
            state_r            <= ST_DIV_PULSE;
          end
        end

        ST_DIV_PULSE: begin
          if (div_done) begin
            result_r <= pulse_clamped;
            state_r  <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Advance once the output register is free or being emptied this cycle
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_pulse_us_r <= result_r;
            state_r        <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pulse_us = out_pulse_us_r;

  // A pulse handed over from the done state shows up in the output register
  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || !out_stall))
      |=> (out_valid_r && out_pulse_us_r == $past(result_r)))
    else $error("done state did not load the output register");

  // The multiplier only finishes while the sequencer waits for it
  a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_INC || state_r == ST_MUL_AMP
                  || state_r == ST_MUL_SPAN))
    else $error("multiplier finished outside a multiply wait");

  // The divider only finishes while the sequencer waits for it
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_INC || state_r == ST_DIV_PULSE))
    else $error("divider finished outside a divide wait");

  // A tick while stopped goes straight to the done state
  a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_kind == sspg_pkg::KIND_TICK && !running_r)
      |=> (state_r == ST_DONE && result_r == $past(pulse_ctr_r)))
    else $error("stopped tick did not answer the centre pulse");

  // The phase moves only at the end of the step division or on a start
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV_INC && !(in_accept && in_kind == sspg_pkg::KIND_START))
      |=> $stable(phase_r))
    else $error("phase changed outside a step update or start");

endmodule

`default_nettype wire

FILE: design/sspg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module sspg_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sspg_pkg::mul_req_t            req,
  output logic                               done,
  output logic [sspg_pkg::MUL_P_W-1:0]       prod
);

  logic [sspg_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [sspg_pkg::MUL_A_W-1:0]   mcand_r;
  logic [sspg_pkg::MUL_ACC_W-1:0] acc_r;
  logic [sspg_pkg::MUL_ACC_W-1:0] acc_nxt;
  logic [sspg_pkg::MUL_A_W:0]     sum;

  // Add the multiplicand into the upper half when the current LSB is set, then shift
  always_comb begin
    sum = {1'b0, acc_r[sspg_pkg::MUL_ACC_W-1:sspg_pkg::MUL_B_W]}
        + (acc_r[0] ? {1'b0, mcand_r} : '0);
    acc_nxt = {sum, acc_r[sspg_pkg::MUL_B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= sspg_pkg::MUL_CNT_W'(sspg_pkg::MUL_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - sspg_pkg::MUL_CNT_W'(1);
        if (cnt_r == sspg_pkg::MUL_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.mcand;
      acc_r   <= {{sspg_pkg::MUL_A_W{1'b0}}, req.mplier};
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r[sspg_pkg::MUL_P_W-1:0];

endmodule

`default_nettype wire

FILE: design/sspg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module sspg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sspg_pkg::div_req_t            req,
  output logic                               done,
  output logic [sspg_pkg::DIV_Q_W-1:0]       quot
);

  logic [sspg_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [sspg_pkg::DIV_D_W-1:0]   divisor_r;
  logic [sspg_pkg::DIV_D_W-1:0]   rem_r;
  logic [sspg_pkg::DIV_N_W-1:0]   dq_r;
  logic [sspg_pkg::DIV_D_W:0]     trial;
  logic [sspg_pkg::DIV_D_W:0]     diff;
  logic                           fits;

  // Bring down the next dividend bit and subtract where the divisor fits
  always_comb begin
    trial = {rem_r, dq_r[sspg_pkg::DIV_N_W-1]};
    diff  = trial - {1'b0, divisor_r};
    fits  = (trial >= {1'b0, divisor_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - sspg_pkg::DIV_CNT_W'(1);
        if (cnt_r == sspg_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor_r <= req.divisor;
      rem_r     <= '0;
      dq_r      <= req.dividend;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[sspg_pkg::DIV_D_W-1:0] : trial[sspg_pkg::DIV_D_W-1:0];
      dq_r  <= {dq_r[sspg_pkg::DIV_N_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = dq_r[sspg_pkg::DIV_Q_W-1:0];

endmodule

`default_nettype wire
